FILE: design/atan2_degrees_polynomial_defines.svh
// ----------------------------------------------------------------------------
// atan2 degrees polynomial: assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ATAN2_DEGREES_POLYNOMIAL_DEFINES_SVH
`define ATAN2_DEGREES_POLYNOMIAL_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ATAN2DP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atan2dp: check failed");
// next-cycle implication
`define ATAN2DP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atan2dp: check failed");
`else
`define ATAN2DP_ASSERT_IMP(label, ante, cons)
`define ATAN2DP_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: design/atan2dp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atan2dp_pkg
// constants and types of the polynomial arctangent pipeline
// ----------------------------------------------------------------------------
package atan2dp_pkg;

    localparam int ANGLE_W     = 9;
    localparam int OUT_TDATA_W = 16;

    // first-octant quartic, centidegrees
    localparam int COEF_A = 829;
    localparam int COEF_B = 2011;
    localparam int COEF_C = 58;
    localparam int COEF_D = 5741;

    localparam int CENTI_180  = 18000;
    localparam int CENTI_90   = 9000;
    localparam int CENTI_HALF = 50;
    localparam int CENTI_LIMIT = 18100;

    // floor(m / 100) as (m * 5243) >> 19, exact for m below 2^15
    localparam int MAG_W        = 15;
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int RPROD_W      = 28;
    localparam int QUO_W        = 8;

    localparam logic signed [ANGLE_W-1:0] ANGLE_0       = 9'sd0;
    localparam logic signed [ANGLE_W-1:0] ANGLE_90      = 9'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_NEG_90  = -9'sd90;
    localparam logic signed [ANGLE_W-1:0] ANGLE_180     = 9'sd180;

    typedef struct packed {
        logic                        special;
        logic signed [ANGLE_W-1:0]   special_angle;
        logic                        xdom;
        logic                        x_neg;
        logic                        y_neg;
    } side_t;

endpackage
`default_nettype wire

FILE: design/atan2_degrees_polynomial.sv
// ----------------------------------------------------------------------------
// atan2_degrees_polynomial
// pipelined vector angle in whole degrees, -180 to 180
//
// input word on s_axis: y_value in the low COMPONENT_WIDTH bits, x_value
// above it. output word on m_axis: angle_degrees in bits [8:0].
// one word enters per cycle. each word spends COMPONENT_WIDTH-independent
// RATIO_FRACTION_BITS+11 register stages in the block (27 at the defaults):
// one setup stage, one restoring divider stage per quotient bit, six
// stages of horner multiply and add, a fold stage, a rounding multiply and
// the output register.
// throughput is one word per cycle while m_axis_tready stays high.
// every stage moves together: when the output register holds a word that
// is not taken, the whole pipeline and s_axis_tready hold, nothing is lost.
// reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "atan2_degrees_polynomial_defines.svh"

module atan2_degrees_polynomial #(
    parameter int COMPONENT_WIDTH     = 16,
    parameter int RATIO_FRACTION_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // y_value, x_value
    input  wire logic [((2*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // angle_degrees
    output logic [atan2dp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import atan2dp_pkg::*;

    localparam int W         = COMPONENT_WIDTH;
    localparam int F         = RATIO_FRACTION_BITS;
    localparam int DIV_STEPS = F + 1;
    localparam int ZW        = F + 1;
    localparam int TW        = F + 16;
    localparam int PW        = TW + F + 2;

    localparam logic [ZW-1:0]        Z_ONE  = ZW'(1) << F;
    localparam logic signed [TW-1:0] K_B    = TW'(COEF_B) << F;
    localparam logic signed [TW-1:0] K_C    = TW'(COEF_C) << F;
    localparam logic signed [TW-1:0] K_D    = TW'(COEF_D) << F;
    localparam logic signed [TW-1:0] K_180  = TW'(CENTI_180) << F;
    localparam logic signed [TW-1:0] K_90   = TW'(CENTI_90) << F;
    localparam logic signed [TW-1:0] K_HALF = TW'(CENTI_HALF) << F;
    localparam logic signed [TW-1:0] K_LIM  = TW'(CENTI_LIMIT) << F;

    // octant codes: {x dominant, x negative}
    localparam logic [1:0] OCT_XDOM_XPOS = 2'b10;
    localparam logic [1:0] OCT_XDOM_XNEG = 2'b11;
    localparam logic [1:0] OCT_YDOM_XPOS = 2'b00;
    localparam logic [1:0] OCT_YDOM_XNEG = 2'b01;

    function automatic logic signed [TW-1:0] z_tw(input logic [ZW-1:0] z);
        return $signed(TW'(z));
    endfunction

    function automatic logic signed [PW-1:0] z_pw(input logic [ZW-1:0] z);
        return $signed(PW'(z));
    endfunction

    logic advance;
    logic out_valid_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ANGLE_W){1'b0}}, out_angle_reg};

    // ---------------- setup: magnitudes, axis cases, octant ----------------
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] x_in;
    logic [W-1:0] ay;
    logic [W-1:0] ax;
    side_t side_next;
    logic [W-1:0] lo_next;
    logic [W-1:0] hi_next;

    assign y_in = $signed(s_axis_tdata[W-1:0]);
    assign x_in = $signed(s_axis_tdata[2*W-1:W]);

    always_comb
    begin
        ay = y_in[W-1] ? W'(-y_in) : W'(y_in);
        ax = x_in[W-1] ? W'(-x_in) : W'(x_in);
        side_next.xdom  = ay < ax;
        side_next.x_neg = x_in[W-1];
        side_next.y_neg = y_in[W-1];
        side_next.special = (y_in == '0) || (x_in == '0);
        if (y_in == '0)
        begin
            side_next.special_angle = x_in[W-1] ? ANGLE_180 : ANGLE_0;
        end
        else
        begin
            side_next.special_angle = y_in[W-1] ? ANGLE_NEG_90 : ANGLE_90;
        end
        lo_next = side_next.xdom ? ay : ax;
        hi_next = side_next.xdom ? ax : ay;
    end

    logic setup_valid_reg;
    logic [W-1:0] setup_lo_reg;
    logic [W-1:0] setup_hi_reg;
    side_t setup_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            setup_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            setup_lo_reg   <= lo_next;
            setup_hi_reg   <= hi_next;
            setup_side_reg <= side_next;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic [W-1:0]         div_rem_reg  [DIV_STEPS];
    logic [W-1:0]         div_hi_reg   [DIV_STEPS];
    logic [ZW-1:0]        div_quo_reg  [DIV_STEPS];
    side_t                div_side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] div_valid_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [W-1:0]  rem_in;
        logic [W-1:0]  hi_in;
        logic [ZW-1:0] quo_in;
        side_t         side_in;
        logic          valid_in;
        logic          bit_set;
        logic [W-1:0]  rem_next;
        logic [ZW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            // integer bit: lo never exceeds hi
            assign rem_in   = setup_lo_reg;
            assign hi_in    = setup_hi_reg;
            assign quo_in   = '0;
            assign side_in  = setup_side_reg;
            assign valid_in = setup_valid_reg;
        end
        else
        begin : g_rest
            // remainder stays below hi, so the top bit is free for the shift
            assign rem_in   = {div_rem_reg[k-1][W-2:0], 1'b0};
            assign hi_in    = div_hi_reg[k-1];
            assign quo_in   = div_quo_reg[k-1];
            assign side_in  = div_side_reg[k-1];
            assign valid_in = div_valid_reg[k-1];
        end

        always_comb
        begin
            bit_set  = rem_in >= hi_in;
            rem_next = bit_set ? (rem_in - hi_in) : rem_in;
            quo_next = {quo_in[ZW-2:0], bit_set};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                div_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                div_rem_reg[k]  <= rem_next;
                div_hi_reg[k]   <= hi_in;
                div_quo_reg[k]  <= quo_next;
                div_side_reg[k] <= side_in;
            end
        end
    end

    // ---------------- horner, fold and rounding stages ----------------
    logic [8:1]    valid_pipe_reg;
    side_t         side_pipe_reg [1:8];
    logic [ZW-1:0] z_pipe_reg    [1:5];

    logic signed [TW-1:0] t1_reg;
    logic signed [PW-1:0] pr1_reg;
    logic signed [TW-1:0] t2_reg;
    logic signed [PW-1:0] pr2_reg;
    logic signed [TW-1:0] t3_reg;
    logic signed [PW-1:0] pr3_reg;
    logic signed [TW-1:0] sum_reg;
    logic                 neg_reg;
    logic [RPROD_W-1:0]   rprod_reg;

    logic signed [TW-1:0] oct_angle;
    logic signed [TW-1:0] fold;
    logic signed [TW-1:0] mag;
    logic [MAG_W-1:0]     mag_deg;
    logic [QUO_W-1:0]     deg_q;
    logic signed [ANGLE_W-1:0] deg_abs;
    logic signed [ANGLE_W-1:0] angle_next;

    always_comb
    begin
        oct_angle = TW'(pr3_reg >>> F);
        case ({side_pipe_reg[6].xdom, side_pipe_reg[6].x_neg})
            OCT_XDOM_XPOS: fold = side_pipe_reg[6].y_neg ? -oct_angle : oct_angle;
            OCT_XDOM_XNEG: fold = side_pipe_reg[6].y_neg ? (oct_angle - K_180)
                                                         : (K_180 - oct_angle);
            OCT_YDOM_XPOS: fold = side_pipe_reg[6].y_neg ? (oct_angle - K_90)
                                                         : (K_90 - oct_angle);
            OCT_YDOM_XNEG: fold = side_pipe_reg[6].y_neg ? (-oct_angle - K_90)
                                                         : (oct_angle + K_90);
            default:       fold = oct_angle;
        endcase

        // truncation toward zero: divide the magnitude, then restore the sign
        mag     = sum_reg[TW-1] ? -sum_reg : sum_reg;
        mag_deg = MAG_W'(mag >> F);

        deg_q   = QUO_W'(rprod_reg >> RECIP_SHIFT);
        deg_abs = $signed({1'b0, deg_q});
        if (side_pipe_reg[8].special)
        begin
            angle_next = side_pipe_reg[8].special_angle;
        end
        else
        begin
            angle_next = neg_reg ? -deg_abs : deg_abs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            valid_pipe_reg <= {valid_pipe_reg[7:1], div_valid_reg[DIV_STEPS-1]};
            out_valid_reg  <= valid_pipe_reg[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_pipe_reg[1] <= div_side_reg[DIV_STEPS-1];
            for (int i = 2; i <= 8; i++)
            begin
                side_pipe_reg[i] <= side_pipe_reg[i-1];
            end
            z_pipe_reg[1] <= div_quo_reg[DIV_STEPS-1];
            for (int i = 2; i <= 5; i++)
            begin
                z_pipe_reg[i] <= z_pipe_reg[i-1];
            end

            t1_reg    <= TW'(COEF_A) * z_tw(div_quo_reg[DIV_STEPS-1]) - K_B;
            pr1_reg   <= PW'(t1_reg) * z_pw(z_pipe_reg[1]);
            t2_reg    <= TW'(pr1_reg >>> F) - K_C;
            pr2_reg   <= PW'(t2_reg) * z_pw(z_pipe_reg[3]);
            t3_reg    <= TW'(pr2_reg >>> F) + K_D;
            pr3_reg   <= PW'(t3_reg) * z_pw(z_pipe_reg[5]);
            sum_reg   <= fold + K_HALF;
            neg_reg   <= sum_reg[TW-1];
            rprod_reg <= RPROD_W'(mag_deg) * RPROD_W'(RECIP_100);
            out_angle_reg <= angle_next;
        end
    end

    `ATAN2DP_ASSERT_IMP(a_ratio_in_range,
        div_valid_reg[DIV_STEPS-1] && !div_side_reg[DIV_STEPS-1].special,
        div_quo_reg[DIV_STEPS-1] <= Z_ONE)
    `ATAN2DP_ASSERT_IMP(a_octant_not_negative,
        valid_pipe_reg[6] && !side_pipe_reg[6].special,
        !pr3_reg[PW-1])
    `ATAN2DP_ASSERT_IMP(a_fold_bounded,
        valid_pipe_reg[7] && !side_pipe_reg[7].special,
        (sum_reg <= K_LIM) && (sum_reg >= -K_LIM))
    `ATAN2DP_ASSERT_NXT(a_axis_case_kept,
        advance && valid_pipe_reg[8] && side_pipe_reg[8].special,
        out_angle_reg == $past(side_pipe_reg[8].special_angle))
    `ATAN2DP_ASSERT_IMP(a_angle_in_range,
        out_valid_reg,
        (out_angle_reg <= ANGLE_180) && (out_angle_reg >= -ANGLE_180))

endmodule
`default_nettype wire
